// ----- rtl/lars_pkg.sv -----
// lars_pkg: shared constants, command and register codes, and the payload,
// configuration and token structs of the local alignment row scorer.
// No dependencies.
package lars_pkg;

  localparam int unsigned REF_MAX = 64;
  localparam int unsigned LEN_W   = $clog2(REF_MAX + 1);
  localparam int unsigned COL_W   = LEN_W;
  localparam int unsigned SCORE_W = 15;
  localparam int unsigned F_W     = 16;
  localparam int unsigned ARITH_W = 18;

  localparam logic signed [ARITH_W-1:0] SCORE_MAX = ARITH_W'(32767);

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_SCORE  = 2'd2;

  localparam logic [1:0] REG_MATCH    = 2'd0;
  localparam logic [1:0] REG_MISMATCH = 2'd1;
  localparam logic [1:0] REG_GAP_OPEN = 2'd2;
  localparam logic [1:0] REG_GAP_EXT  = 2'd3;

  localparam logic [6:0] MATCH_RST    = 7'd5;
  localparam logic [7:0] MISMATCH_RST = 8'hfd;
  localparam logic [6:0] GAP_OPEN_RST = 7'd8;
  localparam logic [6:0] GAP_EXT_RST  = 7'd1;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] symbol;
  } in_item_t;

  typedef struct packed {
    logic [SCORE_W-1:0] row_best;
    logic [6:0]         row_best_column;
    logic [SCORE_W-1:0] overall_best;
  } out_item_t;

  typedef struct packed {
    logic [6:0]        match_score;
    logic signed [7:0] mismatch_score;
    logic [6:0]        gap_open;
    logic [6:0]        gap_extend;
  } cfg_t;

  // row token walking the cell chain, carrying the left-neighbor values
  typedef struct packed {
    logic               valid;
    logic [7:0]         symbol;
    logic [SCORE_W-1:0] diag;
    logic [SCORE_W-1:0] e_left;
    logic [SCORE_W-1:0] hp_left;
    logic [SCORE_W-1:0] best;
    logic [COL_W-1:0]   best_col;
    logic [COL_W-1:0]   pos;
  } token_t;

endpackage

// ----- rtl/lars_cell.sv -----
// lars_cell: one reference column of the scoring chain; holds the reference
// symbol, last-row H and F, and registers the row token for its neighbor.
// Depends on lars_pkg.
module lars_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  logic            active_i,
  input  logic            clr_i,
  input  logic            wr_en_i,
  input  logic [7:0]      wr_sym_i,
  input  lars_pkg::cfg_t   cfg_i,
  input  lars_pkg::token_t tok_i,
  output lars_pkg::token_t tok_o
);
  import lars_pkg::*;

  logic [7:0]               sym_q;
  logic [SCORE_W-1:0]       h_q, h_d;
  logic signed [F_W-1:0]    f_q, f_d;
  token_t                   tok_q, tok_d;

  logic signed [ARITH_W-1:0] h_up_s, f_up_s, open_s, ext_s, sub_s, diag_s;
  logic signed [ARITH_W-1:0] gap_cand, f_max, f_new, dsum, hp_raw, e_raw, e_gap;
  logic [SCORE_W-1:0]        hp, e_new, el;

  always_comb begin
    h_up_s = signed'(ARITH_W'(h_q));
    f_up_s = ARITH_W'(f_q);
    open_s = signed'(ARITH_W'(cfg_i.gap_open));
    ext_s  = signed'(ARITH_W'(cfg_i.gap_extend));
    diag_s = signed'(ARITH_W'(tok_i.diag));
    if (sym_q == tok_i.symbol) begin
      sub_s = signed'(ARITH_W'(cfg_i.match_score));
    end else begin
      sub_s = ARITH_W'(cfg_i.mismatch_score);
    end

    // vertical gap
    gap_cand = h_up_s - open_s;
    f_max    = (f_up_s >= gap_cand) ? f_up_s : gap_cand;
    f_new    = f_max - ext_s;

    // provisional score
    dsum   = diag_s + sub_s;
    hp_raw = (dsum >= f_new) ? dsum : f_new;
    if (hp_raw < 0) begin
      hp_raw = '0;
    end
    hp = (hp_raw > SCORE_MAX) ? SCORE_MAX[SCORE_W-1:0] : hp_raw[SCORE_W-1:0];

    // horizontal gap from the left neighbor
    el    = (tok_i.e_left >= tok_i.hp_left) ? tok_i.e_left : tok_i.hp_left;
    e_raw = signed'(ARITH_W'(el)) - ext_s;
    e_new = (e_raw < 0) ? '0 : e_raw[SCORE_W-1:0];

    e_gap = signed'(ARITH_W'(e_new)) - open_s;
    h_d   = (e_gap > signed'(ARITH_W'(hp))) ? e_gap[SCORE_W-1:0] : hp;
    f_d   = f_new[F_W-1:0];

    tok_d = tok_i;
    if (active_i) begin
      tok_d.diag    = h_q;
      tok_d.e_left  = e_new;
      tok_d.hp_left = hp;
      tok_d.pos     = tok_i.pos + COL_W'(1);
      if (h_d > tok_i.best) begin
        tok_d.best     = h_d;
        tok_d.best_col = tok_i.pos + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      sym_q <= wr_sym_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q   <= '0;
      f_q   <= '0;
      tok_q <= '0;
    end else begin
      if (clr_i || wr_en_i) begin
        h_q <= '0;
        f_q <= '0;
      end else if (adv_i && tok_i.valid && active_i) begin
        h_q <= h_d;
        f_q <= f_d;
      end
      if (adv_i) begin
        tok_q <= tok_d;
      end
    end
  end

  assign tok_o = tok_q;

endmodule

// ----- rtl/local_alignment_row_scorer.sv -----
// local_alignment_row_scorer: affine-gap local alignment row scorer built as
// a chain of lars_cell columns with reference loading and result register.
// Depends on lars_pkg and lars_cell.
//
//   channel  direction  handshake              payload
//   in       input      in_valid_i/in_stall_o   in_data_i (command, symbol)
//   out      output     out_valid_o/out_stall_i out_data_o (row_best, column, overall)
//   cfg      input      cfg_we_i                cfg_addr_i, cfg_wdata_i
//
// clear and append take effect when accepted; a score transaction's row token
// is registered by every cell of the full chain, whatever the loaded length,
// before its result is registered.
// the input is stalled while a row token is in the chain; a result that waits
// on out_stall_i freezes the chain with the token in its last cell.
// reset clears the scores, length, best score and loads the register defaults.
module local_alignment_row_scorer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  lars_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output lars_pkg::out_item_t out_data_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_addr_i,
  input  logic [7:0]          cfg_wdata_i
);
  import lars_pkg::*;

  cfg_t               cfg_q;
  logic [LEN_W-1:0]   ref_len_q;
  logic               busy_q;
  logic [SCORE_W-1:0] best_q, best_d;
  logic               out_valid_q;
  out_item_t          out_q;

  token_t             tok [REF_MAX+1];
  logic               in_fire, clear_fire, append_fire, score_fire;
  logic               adv, exit_fire;

  assign in_fire     = in_valid_i && !busy_q;
  assign clear_fire  = in_fire && (in_data_i.command == CMD_CLEAR);
  assign append_fire = in_fire && (in_data_i.command == CMD_APPEND)
                       && (ref_len_q != LEN_W'(REF_MAX));
  assign score_fire  = in_fire && (in_data_i.command == CMD_SCORE);

  assign adv       = !(tok[REF_MAX].valid && out_valid_q && out_stall_i);
  assign exit_fire = tok[REF_MAX].valid && adv;

  always_comb begin
    tok[0]        = '0;
    tok[0].valid  = score_fire;
    tok[0].symbol = in_data_i.symbol;
  end

  for (genvar j = 0; j < REF_MAX; j++) begin : g_cell
    lars_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .adv_i    (adv),
      .active_i (ref_len_q > LEN_W'(j)),
      .clr_i    (clear_fire),
      .wr_en_i  (append_fire && (ref_len_q == LEN_W'(j))),
      .wr_sym_i (in_data_i.symbol),
      .cfg_i    (cfg_q),
      .tok_i    (tok[j]),
      .tok_o    (tok[j+1])
    );
  end

  always_comb begin
    best_d = best_q;
    if (clear_fire) begin
      best_d = '0;
    end else if (exit_fire && (tok[REF_MAX].best > best_q)) begin
      best_d = tok[REF_MAX].best;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exit_fire) begin
      out_q.row_best        <= tok[REF_MAX].best;
      out_q.row_best_column <= 7'(tok[REF_MAX].best_col);
      out_q.overall_best    <= best_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.match_score    <= MATCH_RST;
      cfg_q.mismatch_score <= MISMATCH_RST;
      cfg_q.gap_open       <= GAP_OPEN_RST;
      cfg_q.gap_extend     <= GAP_EXT_RST;
      ref_len_q            <= '0;
      busy_q               <= 1'b0;
      best_q               <= '0;
      out_valid_q          <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          REG_MATCH:    cfg_q.match_score    <= cfg_wdata_i[6:0];
          REG_MISMATCH: cfg_q.mismatch_score <= cfg_wdata_i;
          REG_GAP_OPEN: cfg_q.gap_open       <= cfg_wdata_i[6:0];
          REG_GAP_EXT:  cfg_q.gap_extend     <= cfg_wdata_i[6:0];
          default: ;
        endcase
      end
      if (clear_fire) begin
        ref_len_q <= '0;
      end else if (append_fire) begin
        ref_len_q <= ref_len_q + LEN_W'(1);
      end
      if (score_fire) begin
        busy_q <= 1'b1;
      end else if (exit_fire) begin
        busy_q <= 1'b0;
      end
      best_q <= best_d;
      if (exit_fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_stall_o  = busy_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- verif/tb_local_alignment_row_scorer.sv -----
// tb_local_alignment_row_scorer: self-checking testbench for the affine-gap
// local alignment row scorer, with its own row predictor and random traffic.
// Depends on lars_pkg and the local_alignment_row_scorer RTL.
module tb_local_alignment_row_scorer;
  import lars_pkg::*;

  localparam logic [1:0] CMD_UNUSED  = 2'd3;
  localparam int         CYCLE_LIMIT = 1_000_000;
  localparam int         LONG_HOLD   = 400;
  localparam int         PHASE_ITEMS = 186;

  logic      clk_i = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_addr = '0;
  logic [7:0] cfg_wdata = '0;

  local_alignment_row_scorer DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_addr_i  (cfg_addr),
    .cfg_wdata_i (cfg_wdata)
  );

  always #2 clk_i = ~clk_i;

  // scoring registers as the block should hold them
  int cur_match, cur_mismatch, cur_open, cur_extend;

  // alignment state of the predictor
  logic [7:0] ref_syms [REF_MAX];
  int         ref_len;
  int         h_prev [REF_MAX];
  int         f_prev [REF_MAX];
  int         best_run;

  in_item_t  pending_items [$];
  out_item_t expected_rows [$];

  int errors = 0;
  int cycles = 0;
  int results_seen = 0;
  int gap_left = 0;
  int burst_left = 0;
  int hold_left = 0;
  int run_left = 0;
  bit stall_phase = 1'b0;
  int gen_count, gen_len;
  logic [7:0] alphabet [4];
  out_item_t want;

  function automatic int max_int(int a, int b);
    return a >= b ? a : b;
  endfunction

  function automatic int sat_score(int v);
    return v > 32767 ? 32767 : v;
  endfunction

  function automatic void clear_alignment_state();
    ref_len = 0;
    best_run = 0;
    foreach (h_prev[i]) begin
      h_prev[i] = 0;
      f_prev[i] = 0;
    end
  endfunction

  // one accepted transaction through the recurrence; a score yields one row
  function automatic void predict_row(in_item_t t);
    int diag = 0;
    int e_left = 0;
    int hp_left = 0;
    int row_best = 0;
    int col = 0;
    int h_up, s, f, hp, e, h, j;
    out_item_t r;
    case (t.command)
      CMD_CLEAR: clear_alignment_state();
      CMD_APPEND: begin
        if (ref_len < REF_MAX) begin
          ref_syms[ref_len] = t.symbol;
          h_prev[ref_len] = 0;
          f_prev[ref_len] = 0;
          ref_len++;
        end
      end
      CMD_SCORE: begin
        for (j = 0; j < ref_len; j++) begin
          h_up = h_prev[j];
          s = (ref_syms[j] == t.symbol) ? cur_match : cur_mismatch;
          f = max_int(f_prev[j], h_up - cur_open) - cur_extend;
          hp = sat_score(max_int(max_int(diag + s, f), 0));
          e = max_int(0, max_int(e_left, hp_left) - cur_extend);
          h = sat_score(max_int(hp, e - cur_open));
          diag = h_up;
          h_prev[j] = h;
          f_prev[j] = f;
          e_left = e;
          hp_left = hp;
          if (h > row_best) begin
            row_best = h;
            col = j + 1;
          end
        end
        if (row_best > best_run) best_run = row_best;
        r.row_best = SCORE_W'(row_best);
        r.row_best_column = 7'(col);
        r.overall_best = SCORE_W'(best_run);
        expected_rows.push_back(r);
      end
      default: ;
    endcase
  endfunction

  function automatic int next_gap();
    int p;
    if (burst_left != 0) begin
      burst_left--;
      return 0;
    end
    p = $urandom_range(0, 99);
    if (p < 4) begin
      burst_left = $urandom_range(30, 120);
      return 0;
    end
    if (p < 50) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 80);
  endfunction

  // driver: prediction happens on the accepting edge
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
    end else begin
      if (in_valid && !in_stall) predict_row(in_data);
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          in_valid <= 1'b1;
          in_data <= pending_items.pop_front();
          gap_left = next_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_row(out_item_t got);
    if (expected_rows.size() == 0) begin
      $error("unexpected row result: row_best %0d column %0d overall %0d",
             got.row_best, got.row_best_column, got.overall_best);
      errors++;
    end else begin
      want = expected_rows.pop_front();
      if (got.row_best !== want.row_best) begin
        $error("row_best: expected %0d, got %0d", want.row_best, got.row_best);
        errors++;
      end
      if (got.row_best_column !== want.row_best_column) begin
        $error("row_best_column: expected %0d, got %0d",
               want.row_best_column, got.row_best_column);
        errors++;
      end
      if (got.overall_best !== want.overall_best) begin
        $error("overall_best: expected %0d, got %0d", want.overall_best, got.overall_best);
        errors++;
      end
    end
  endtask

  // monitor: checks results and drives a random stall pattern
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        check_row(out_data);
        results_seen++;
        // long hold-off so the chain freezes and the input backs up
        if (results_seen == 5 || results_seen == 250) hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (run_left == 0) begin
          case ($urandom_range(0, 9))
            0, 1, 2: begin stall_phase = 1'b1; run_left = $urandom_range(0, 2); end
            3:       begin stall_phase = 1'b1; run_left = $urandom_range(4, 20); end
            4: begin
              stall_phase = ($urandom_range(0, 3) == 0);
              run_left = stall_phase ? $urandom_range(30, 100) : $urandom_range(100, 300);
            end
            default: begin stall_phase = 1'b0; run_left = $urandom_range(0, 15); end
          endcase
        end else begin
          run_left--;
        end
        out_stall <= stall_phase;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // items the block acts on count toward the phase size
  task automatic add_item(logic [1:0] cmd, logic [7:0] sym);
    in_item_t t;
    t.command = cmd;
    t.symbol = sym;
    pending_items.push_back(t);
    case (cmd)
      CMD_CLEAR: begin gen_count++; gen_len = 0; end
      CMD_APPEND: begin
        if (gen_len < REF_MAX) begin
          gen_count++;
          gen_len++;
        end
      end
      CMD_SCORE: gen_count++;
      default: ;
    endcase
  endtask

  function automatic logic [7:0] pick_symbol();
    if ($urandom_range(0, 7) == 0) return 8'($urandom);
    return alphabet[$urandom_range(0, 3)];
  endfunction

  // mostly clear, load a reference and score rows against it; some noise
  task automatic fill_random(int target);
    int k;
    gen_count = 0;
    while (gen_count < target) begin
      if ($urandom_range(0, 99) < 80) begin
        if ($urandom_range(0, 9) < 8) add_item(CMD_CLEAR, 8'($urandom));
        foreach (alphabet[i]) alphabet[i] = 8'($urandom);
        k = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 20);
        repeat (k) add_item(CMD_APPEND, pick_symbol());
        repeat ($urandom_range(1, 10)) begin
          if ($urandom_range(0, 9) == 0) add_item(CMD_APPEND, pick_symbol());
          add_item(CMD_SCORE, pick_symbol());
        end
      end else begin
        repeat ($urandom_range(1, 4)) add_item(2'($urandom_range(0, 3)), 8'($urandom));
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || in_valid || expected_rows.size() != 0)
      @(negedge clk_i);
    // clear and append give no result, let the chain settle
    repeat (REF_MAX + 8) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, int value);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= 8'(value);
    case (idx)
      REG_MATCH:    cur_match = value & 'h7f;
      REG_MISMATCH: cur_mismatch = int'($signed(8'(value)));
      REG_GAP_OPEN: cur_open = value & 'h7f;
      REG_GAP_EXT:  cur_extend = value & 'h7f;
      default: ;
    endcase
  endtask

  task automatic write_settings(int m, int mm, int o, int e);
    write_reg(REG_MATCH, m);
    write_reg(REG_MISMATCH, mm);
    write_reg(REG_GAP_OPEN, o);
    write_reg(REG_GAP_EXT, e);
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  initial begin
    cur_match = int'(MATCH_RST);
    cur_mismatch = int'($signed(MISMATCH_RST));
    cur_open = int'(GAP_OPEN_RST);
    cur_extend = int'(GAP_EXT_RST);
    foreach (ref_syms[i]) ref_syms[i] = '0;
    clear_alignment_state();
    gen_len = 0;

    // directed: empty reference, unused command, symbol extremes, append
    // after scored rows, clear, repeated matches
    gen_count = 0;
    add_item(CMD_SCORE, 8'h00);
    add_item(CMD_UNUSED, 8'hff);
    add_item(CMD_APPEND, 8'h00);
    add_item(CMD_APPEND, 8'hff);
    add_item(CMD_APPEND, 8'haa);
    add_item(CMD_APPEND, 8'h55);
    add_item(CMD_SCORE, 8'h00);
    add_item(CMD_SCORE, 8'hff);
    add_item(CMD_SCORE, 8'h55);
    add_item(CMD_SCORE, 8'h12);
    add_item(CMD_UNUSED, 8'h00);
    add_item(CMD_APPEND, 8'haa);
    add_item(CMD_SCORE, 8'haa);
    add_item(CMD_CLEAR, 8'hff);
    add_item(CMD_SCORE, 8'h00);
    add_item(CMD_APPEND, 8'h41);
    add_item(CMD_SCORE, 8'h41);
    add_item(CMD_SCORE, 8'h41);
    add_item(CMD_SCORE, 8'hbe);
    fill_random(PHASE_ITEMS - 19);

    repeat (5) @(posedge clk_i);
    rst_n <= 1'b1;

    wait_drained();
    write_settings(127, -128, 127, 127);
    @(negedge clk_i);
    fill_random(PHASE_ITEMS);

    wait_drained();
    write_settings(127, 0, 0, 0);
    @(negedge clk_i);
    fill_random(PHASE_ITEMS);

    wait_drained();
    write_settings(0, -1, 3, 0);
    @(negedge clk_i);
    fill_random(PHASE_ITEMS);

    wait_drained();
    write_settings($urandom_range(0, 127), -int'($urandom_range(0, 128)),
                   $urandom_range(0, 127), $urandom_range(0, 12));
    @(negedge clk_i);
    fill_random(PHASE_ITEMS);

    wait_drained();
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/lars_pkg.sv
rtl/lars_cell.sv
rtl/local_alignment_row_scorer.sv
verif/tb_local_alignment_row_scorer.sv
